// File: src/csv_field_tokenizer_top_macros.svh
// assertion macros shared by the tokenizer rtl
// no dependencies; included by modules that carry assertions
`ifndef CSV_FIELD_TOKENIZER_TOP_MACROS_SVH
`define CSV_FIELD_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication
`define CFT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cft assertion failed");

// next-cycle implication
`define CFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cft assertion failed");

`endif

// File: src/cft_pkg.sv
// types and constants of the csv field tokenizer
// no dependencies
`default_nettype none
package cft_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

  localparam logic [7:0] SEPARATOR_RESET = 8'd59;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;
  localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
  localparam logic [7:0] ZERO_BYTE       = 8'd0;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  field_byte;
    logic [5:0]  column_index;
    logic [15:0] row_index;
    logic        field_truncated;
    logic [6:0]  first_row_columns;
  } result_t;

  typedef struct packed {
    logic [7:0] separator_char;
    logic [7:0] quote_char;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/csv_field_tokenizer_top.sv
// top level of the csv field tokenizer: input register, parser, result register
// depends on cft_pkg, cft_regs, cft_parser and csv_field_tokenizer_top_macros.svh
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    item (command, text_byte)
//  result    out        result_valid / result_stall result (event and indices)
//  config    in         psel / penable / pready    paddr, pwdata, prdata
//
// one byte per cycle unless the result stalls; results pass the input and result registers
// the only loop is the parse state update, computed combinationally from the input register
// bytes that give no result leave the pipeline without occupying the result register
// rst is synchronous and clears all control state and the registers to their defaults
// a stalled result holds a valid input register, which then stalls the item channel
`default_nettype none
`include "csv_field_tokenizer_top_macros.svh"
module csv_field_tokenizer_top #(
  parameter int unsigned FIELD_LENGTH_MAX = 256,
  parameter int unsigned COLUMNS_MAX      = 64,
  parameter int unsigned ROWS_MAX         = 65536
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire cft_pkg::item_t             item,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output cft_pkg::result_t                result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cft_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cft_pkg::DATA_W-1:0] pwdata,
  output logic      [cft_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import cft_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t res;

  cft_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cft_parser #(
    .FIELD_LENGTH_MAX (FIELD_LENGTH_MAX),
    .COLUMNS_MAX      (COLUMNS_MAX),
    .ROWS_MAX         (ROWS_MAX)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item_q),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign advance    = !result_valid || !result_stall;
  assign fire       = item_q_valid && advance;
  assign item_stall = item_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  `CFT_ASSERT_NOW(a_stall_needs_item, clk, rst, item_stall, item_q_valid && result_valid)
  `CFT_ASSERT_NEXT(a_held_result, clk, rst, result_valid && result_stall, result_valid && $stable(result))
  `CFT_ASSERT_NEXT(a_idle_no_result, clk, rst, advance && !fire, !result_valid)

endmodule
`default_nettype wire

// File: src/cft_regs.sv
// configuration registers behind the apb-style port
// depends on cft_pkg
`default_nettype none
module cft_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cft_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cft_pkg::DATA_W-1:0] pwdata,
  output logic      [cft_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output cft_pkg::cfg_t                   cfg
);
  import cft_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator_char <= SEPARATOR_RESET;
      cfg.quote_char     <= QUOTE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SEPARATOR: cfg.separator_char <= pwdata[7:0];
        REG_QUOTE:     cfg.quote_char     <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SEPARATOR: prdata = {{(DATA_W-8){1'b0}}, cfg.separator_char};
      REG_QUOTE:     prdata = {{(DATA_W-8){1'b0}}, cfg.quote_char};
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/cft_parser.sv
// parse state and per-byte decision logic of the tokenizer
// depends on cft_pkg and csv_field_tokenizer_top_macros.svh
`default_nettype none
`include "csv_field_tokenizer_top_macros.svh"
module cft_parser #(
  parameter int unsigned FIELD_LENGTH_MAX = 256,
  parameter int unsigned COLUMNS_MAX      = 64,
  parameter int unsigned ROWS_MAX         = 65536
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire cft_pkg::item_t item,
  input  wire cft_pkg::cfg_t  cfg,
  output logic                res_valid,
  output cft_pkg::result_t    res
);
  import cft_pkg::*;

  localparam int unsigned FLW  = $clog2(FIELD_LENGTH_MAX + 1);
  localparam int unsigned CW   = (COLUMNS_MAX > 1) ? $clog2(COLUMNS_MAX) : 1;
  localparam int unsigned FW   = $clog2(COLUMNS_MAX + 1);
  localparam int unsigned RW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int unsigned CWX  = (CW > 6) ? CW : 6;
  localparam int unsigned FWX  = (FW > 7) ? FW : 7;
  localparam int unsigned RWX  = (RW > 16) ? RW : 16;

  typedef enum logic [3:0] {
    MODE_PLAIN      = 4'b0001,
    MODE_QUOTED     = 4'b0010,
    MODE_QUOTE_SEEN = 4'b0100,
    MODE_CLOSED     = 4'b1000
  } mode_t;

  mode_t          parse_mode, parse_mode_next;
  logic [FLW-1:0] field_length, field_length_next;
  logic           truncated_mark, truncated_mark_next;
  logic [CW-1:0]  column_counter, column_counter_next;
  logic [RW-1:0]  row_counter, row_counter_next;
  logic [FW-1:0]  first_row_count, first_row_count_next;
  logic           in_first_row, in_first_row_next;
  logic           line_has_content, line_has_content_next;

  logic           do_end;
  logic           row_end;
  logic           do_data;
  logic           is_quote;
  logic           is_sep;
  logic [7:0]     b;
  logic [CWX-1:0] col_ext;
  logic [FWX-1:0] frc_ext;
  logic [RWX-1:0] row_ext;

  assign b        = item.text_byte;
  assign is_quote = (b == cfg.quote_char);
  assign is_sep   = (b == cfg.separator_char);

  // decide what this byte does
  always_comb begin
    do_end                = 1'b0;
    row_end               = 1'b0;
    do_data               = 1'b0;
    parse_mode_next       = parse_mode;
    line_has_content_next = line_has_content;
    if (item.command == CMD_END) begin
      if (line_has_content) begin
        do_end  = 1'b1;
        row_end = 1'b1;
      end
    end else if (b == NEWLINE_BYTE) begin
      do_end  = 1'b1;
      row_end = 1'b1;
    end else begin
      line_has_content_next = 1'b1;
      case (parse_mode)
        MODE_PLAIN: begin
          if (field_length == '0 && !truncated_mark && is_quote) begin
            parse_mode_next = MODE_QUOTED;
          end else if (is_sep) begin
            do_end = 1'b1;
          end else begin
            do_data = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            parse_mode_next = MODE_QUOTE_SEEN;
          end else begin
            do_data = 1'b1;
          end
        end
        MODE_QUOTE_SEEN: begin
          if (is_quote) begin
            parse_mode_next = MODE_QUOTED;
            do_data         = 1'b1;
          end else if (is_sep) begin
            do_end = 1'b1;
          end else begin
            parse_mode_next = MODE_CLOSED;
          end
        end
        MODE_CLOSED: begin
          if (is_sep) begin
            do_end = 1'b1;
          end
        end
        default: parse_mode_next = MODE_PLAIN;
      endcase
    end
  end

  // state update and result
  always_comb begin
    field_length_next    = field_length;
    truncated_mark_next  = truncated_mark;
    column_counter_next  = column_counter;
    row_counter_next     = row_counter;
    first_row_count_next = first_row_count;
    in_first_row_next    = in_first_row;
    res_valid            = 1'b0;
    res.event_kind       = KIND_DATA;
    res.field_byte       = b;
    res.field_truncated  = 1'b0;
    if (do_data) begin
      if (field_length < FLW'(FIELD_LENGTH_MAX)) begin
        field_length_next = field_length + FLW'(1);
        res_valid         = 1'b1;
      end else begin
        truncated_mark_next = 1'b1;
      end
    end
    if (do_end) begin
      res_valid           = 1'b1;
      res.event_kind      = row_end ? KIND_ROW_END : KIND_FIELD_END;
      res.field_byte      = ZERO_BYTE;
      res.field_truncated = truncated_mark;
      if (in_first_row && first_row_count < FW'(COLUMNS_MAX)) begin
        first_row_count_next = first_row_count + FW'(1);
      end
      field_length_next   = '0;
      truncated_mark_next = 1'b0;
      if (row_end) begin
        column_counter_next = '0;
        if (row_counter < RW'(ROWS_MAX - 1)) begin
          row_counter_next = row_counter + RW'(1);
        end
        in_first_row_next = 1'b0;
      end else if (column_counter < CW'(COLUMNS_MAX - 1)) begin
        column_counter_next = column_counter + CW'(1);
      end
    end
    col_ext               = CWX'(column_counter);
    row_ext               = RWX'(row_counter);
    frc_ext               = FWX'(first_row_count_next);
    res.column_index      = col_ext[5:0];
    res.row_index         = row_ext[15:0];
    res.first_row_columns = frc_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode       <= MODE_PLAIN;
      field_length     <= '0;
      truncated_mark   <= 1'b0;
      column_counter   <= '0;
      row_counter      <= '0;
      first_row_count  <= '0;
      in_first_row     <= 1'b1;
      line_has_content <= 1'b0;
    end else if (fire) begin
      parse_mode       <= do_end ? MODE_PLAIN : parse_mode_next;
      field_length     <= field_length_next;
      truncated_mark   <= truncated_mark_next;
      column_counter   <= column_counter_next;
      row_counter      <= row_counter_next;
      first_row_count  <= first_row_count_next;
      in_first_row     <= in_first_row_next;
      line_has_content <= row_end ? 1'b0 : line_has_content_next;
    end
  end

  `CFT_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, field_length <= FLW'(FIELD_LENGTH_MAX))
  `CFT_ASSERT_NOW(a_data_not_trunc, clk, rst, res_valid && res.event_kind == KIND_DATA, !res.field_truncated)
  `CFT_ASSERT_NEXT(a_row_end_clears, clk, rst, fire && res_valid && res.event_kind == KIND_ROW_END, column_counter == '0 && !in_first_row && field_length == '0)
  `CFT_ASSERT_NOW(a_trunc_needs_full, clk, rst, truncated_mark, field_length == FLW'(FIELD_LENGTH_MAX))

endmodule
`default_nettype wire
